FILE: src/fir_lp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fir_lp_pkg;

    // Accumulator and rounding
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 15;
    localparam int Q_W    = ACC_W - FRAC_W;

    // Coefficient set, Q0.15
    localparam int COEF_W     = 16;
    localparam int COEF_COUNT = 32;
    localparam int COEF_IDX_W = $clog2(COEF_COUNT);

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [ACC_W-1:0]         acc_t;

    localparam coef_t COEF_TBL [COEF_COUNT] = '{
        -16'sd293,  -16'sd581,  -16'sd818,  -16'sd959,
        -16'sd967,  -16'sd814,  -16'sd490,   16'sd0,
         16'sd630,   16'sd1358,  16'sd2130,  16'sd2882,
         16'sd3551,  16'sd4077,  16'sd4413,  16'sd4529,
         16'sd4413,  16'sd4077,  16'sd3551,  16'sd2882,
         16'sd2130,  16'sd1358,  16'sd630,   16'sd0,
        -16'sd490,  -16'sd814,  -16'sd967,  -16'sd959,
        -16'sd818,  -16'sd581,  -16'sd293,   16'sd0
    };

    // Taps beyond the table carry a zero coefficient
    function automatic coef_t coef_at(input int k);
        coef_t c;
        c = '0;
        if (k < COEF_COUNT)
        begin
            c = COEF_TBL[COEF_IDX_W'(k)];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/fir_lp_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fir_lp_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: src/fir_lp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fir_lp_result_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

`default_nettype wire

FILE: src/fir_lowpass_32tap_top.sv
`timescale 1ns / 1ps
`default_nettype none

// 32-tap low-pass FIR filter, 3 kHz cut-off at 48 kHz, fixed Q0.15 coefficients.
//
// Channels: samp takes one signed sample per transaction (valid/ready);
// filt returns one transaction per sample with the rounded, saturated
// result and a clipped flag. Results leave in sample order.
//
// Throughput: one sample per cycle while filt.ready is high. A sample
// accepted on samp passes through these registers in order:
// delay-line register, product register, one adder-tree level per
// register stage, then the round/saturate result register.
//
// Stalls: when filt.ready is low the result register holds; earlier stages
// keep filling bubbles, so samp.ready stays high until every stage holds a
// transaction. Up to $clog2(TAPS)+3 transactions can be in flight.
//
// Reset (rst_n low, asynchronous): the delay line clears to zero and all
// stage valids drop; no result is pending afterwards.
module fir_lowpass_32tap_top #(
    parameter int TAPS         = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fir_lp_sample_if.sink      samp,
    fir_lp_result_if.source    filt
);

    // delay line -> multiply/add tree
    logic                              win_valid;
    logic                              win_ready;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] win_taps;

    // tree -> rounding
    logic                              sum_valid;
    logic                              sum_ready;
    fir_lp_pkg::acc_t                  sum;

    logic                              samp_ready;

    assign samp.ready = samp_ready;

    fir_lp_window #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (samp.valid),
        .up_ready  (samp_ready),
        .up_sample (samp.sample),
        .dn_valid  (win_valid),
        .dn_ready  (win_ready),
        .dn_taps   (win_taps)
    );

    fir_lp_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (win_valid),
        .up_ready (win_ready),
        .up_taps  (win_taps),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .dn_sum   (sum)
    );

    fir_lp_round #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .up_sum   (sum),
        .filt     (filt)
    );

endmodule

`default_nettype wire

FILE: src/fir_lp_window.sv
`timescale 1ns / 1ps
`default_nettype none

// Delay line: holds the newest sample and the TAPS-1 before it.
module fir_lp_window #(
    parameter int TAPS         = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               up_valid,
    output logic                                    up_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]            up_sample,
    output logic                                    dn_valid,
    input  wire logic                               dn_ready,
    output logic [TAPS-1:0][SAMPLE_WIDTH-1:0]       dn_taps
);

    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] win_reg;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] win_next;
    logic                              vld_reg;
    logic                              vld_next;
    logic                              accept;

    assign up_ready = !vld_reg || dn_ready;
    assign accept   = up_valid && up_ready;
    assign dn_valid = vld_reg;
    assign dn_taps  = win_reg;

    always_comb
    begin
        win_next = win_reg;
        vld_next = vld_reg;
        if (up_ready)
        begin
            vld_next = up_valid;
        end
        if (accept)
        begin
            // shift in the new sample, drop the oldest
            win_next = {win_reg[TAPS-2:0], up_sample};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            win_reg <= win_next;
            vld_reg <= vld_next;
        end
    end

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (win_reg[1] == $past(win_reg[0])) && (win_reg[0] == $past(up_sample)))
        else $error("delay line did not advance by one sample");

endmodule

`default_nettype wire

FILE: src/fir_lp_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Tap products and a registered binary adder tree, one level per stage.
module fir_lp_mac #(
    parameter int TAPS         = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               up_valid,
    output logic                                    up_ready,
    input  wire logic [TAPS-1:0][SAMPLE_WIDTH-1:0]  up_taps,
    output logic                                    dn_valid,
    input  wire logic                               dn_ready,
    output fir_lp_pkg::acc_t                        dn_sum
);

    localparam int LEVELS = $clog2(TAPS);
    localparam int LEAVES = 1 << LEVELS;
    localparam int NS     = LEVELS + 1;     // product stage plus tree levels
    localparam int PW     = SAMPLE_WIDTH + fir_lp_pkg::COEF_W;

    // stage LEVELS holds the products, stage d holds tree depth d (0 = root)
    logic [NS-1:0]            vld_reg;
    logic [NS-1:0]            vld_next;
    logic [NS-1:0]            rdy;
    logic [NS-1:0]            src_vld;

    fir_lp_pkg::acc_t prod_reg  [TAPS];
    fir_lp_pkg::acc_t prod_next [TAPS];
    fir_lp_pkg::acc_t leaf      [LEAVES];
    fir_lp_pkg::acc_t sum_reg   [1:LEAVES-1];
    fir_lp_pkg::acc_t sum_next  [1:LEAVES-1];
    logic             node_ld   [1:LEAVES-1];

    // Ready ripples back through empty stages
    always_comb
    begin
        rdy[0] = !vld_reg[0] || dn_ready;
        for (int s = 1; s < NS; s++)
        begin
            rdy[s] = !vld_reg[s] || rdy[s-1];
        end
    end

    always_comb
    begin
        src_vld[NS-1] = up_valid;
        for (int s = 0; s < NS - 1; s++)
        begin
            src_vld[s] = vld_reg[s+1];
        end
        for (int s = 0; s < NS; s++)
        begin
            vld_next[s] = rdy[s] ? src_vld[s] : vld_reg[s];
        end
    end

    assign up_ready = rdy[NS-1];
    assign dn_valid = vld_reg[0];
    assign dn_sum   = sum_reg[1];

    // Products, sign-extended to the accumulator width
    for (genvar k = 0; k < TAPS; k++)
    begin : g_prod
        logic signed [PW-1:0] pm;
        assign pm           = $signed(up_taps[k]) * fir_lp_pkg::coef_at(k);
        assign prod_next[k] = fir_lp_pkg::ACC_W'(pm);
    end

    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j < TAPS)
        begin : g_real
            assign leaf[j] = prod_reg[j];
        end
        else
        begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // Heap-ordered tree: node i sums nodes 2i and 2i+1
    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        localparam int D = $clog2(i + 1) - 1;
        assign node_ld[i] = rdy[D] && vld_reg[D+1];
        if (2 * i >= LEAVES)
        begin : g_bottom
            assign sum_next[i] = leaf[2*i-LEAVES] + leaf[2*i+1-LEAVES];
        end
        else
        begin : g_inner
            assign sum_next[i] = sum_reg[2*i] + sum_reg[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1] && up_valid)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        for (int i = 1; i < LEAVES; i++)
        begin
            if (node_ld[i])
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !up_ready |-> (&vld_reg) && !dn_ready)
        else $error("tree refused a transaction while a stage was empty");

    a_hold_root: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !dn_ready) |=> vld_reg[0] && $stable(dn_sum))
        else $error("root sum changed while stalled");

endmodule

`default_nettype wire

FILE: src/fir_lp_round.sv
`timescale 1ns / 1ps
`default_nettype none

// Round, shift down and saturate into the result register.
module fir_lp_round #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire fir_lp_pkg::acc_t  up_sum,
    fir_lp_result_if.source        filt
);

    localparam int QW = fir_lp_pkg::Q_W;
    localparam int VW = (QW > SAMPLE_WIDTH) ? QW : SAMPLE_WIDTH;

    localparam logic signed [VW-1:0] MAX_V =
        {{(VW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN_V = ~MAX_V;

    localparam logic [SAMPLE_WIDTH-1:0] MAX_OUT = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] MIN_OUT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    fir_lp_pkg::acc_t             rnd;
    logic signed [QW-1:0]         q;
    logic signed [VW-1:0]         q_ext;
    logic signed [VW-1:0]         sat;
    logic                         clip;

    logic [SAMPLE_WIDTH-1:0]      filt_reg;
    logic [SAMPLE_WIDTH-1:0]      filt_next;
    logic                         clip_reg;
    logic                         vld_reg;
    logic                         vld_next;
    logic                         load;

    // add half an LSB of the result, wrapping at the accumulator width
    assign rnd   = up_sum + fir_lp_pkg::ACC_W'(1 << (fir_lp_pkg::FRAC_W - 1));
    assign q     = $signed(rnd[fir_lp_pkg::ACC_W-1:fir_lp_pkg::FRAC_W]);
    assign q_ext = VW'(q);

    always_comb
    begin
        sat  = q_ext;
        clip = 1'b0;
        if (q_ext > MAX_V)
        begin
            sat  = MAX_V;
            clip = 1'b1;
        end
        else if (q_ext < MIN_V)
        begin
            sat  = MIN_V;
            clip = 1'b1;
        end
        filt_next = sat[SAMPLE_WIDTH-1:0];
    end

    assign up_ready = !vld_reg || filt.ready;
    assign load     = up_valid && up_ready;

    assign filt.valid    = vld_reg;
    assign filt.filtered = filt_reg;
    assign filt.clipped  = clip_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (up_ready)
        begin
            vld_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            filt_reg <= filt_next;
            clip_reg <= clip;
        end
    end

    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && clip_reg) |-> (filt_reg == MAX_OUT) || (filt_reg == MIN_OUT))
        else $error("clipped result is not at a rail");

endmodule

`default_nettype wire
